// File: hw/rtl/sts_pkg.sv
package sts_pkg;

    localparam int CMD_W       = 1;
    localparam int INDEX_W     = 5;
    localparam int VALUE_W     = 32;
    localparam int RANGE_END_W = 6;
    // Search bounds run from -32 up to 32, so they need a sign and one extra bit.
    localparam int IDX_W       = 7;
    // Highest index that the range fields can name.
    localparam int PORT_MAX    = 31;

    typedef logic signed [IDX_W-1:0]   t_idx;
    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic hit;
        logic finished;
        t_idx next_lo;
        t_idx next_hi;
        t_idx next_mid;
    } t_step;

    // Midpoint of two non-negative bounds, rounded down.
    function automatic t_idx f_mid(t_idx lo, t_idx hi);
        t_idx sum;
        sum = lo + hi;
        return sum >>> 1;
    endfunction

endpackage

// File: hw/rtl/sts_table_ram.sv
module sts_table_ram #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_wr_addr,
    input  logic signed [sts_pkg::VALUE_W-1:0]   i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_rd_addr,
    output logic signed [sts_pkg::VALUE_W-1:0]   o_rd_data
);
    import sts_pkg::*;

    t_value r_mem [TABLE_DEPTH];
    t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/sts_probe_step.sv
module sts_probe_step (
    input  sts_pkg::t_idx   i_lo,
    input  sts_pkg::t_idx   i_hi,
    input  sts_pkg::t_idx   i_mid,
    input  sts_pkg::t_value i_entry,
    input  sts_pkg::t_value i_key,
    output sts_pkg::t_step  o_step
);
    import sts_pkg::*;

    logic greater;
    t_idx lo_nx;
    t_idx hi_nx;

    always_comb begin
        greater = (i_entry > i_key);
        lo_nx   = i_lo;
        hi_nx   = i_hi;
        // Narrow the window to the side that can still hold the key.
        if (greater) begin
            hi_nx = i_mid - t_idx'(1);
        end else begin
            lo_nx = i_mid + t_idx'(1);
        end
        o_step.hit      = (i_entry == i_key);
        o_step.finished = o_step.hit || (lo_nx > hi_nx);
        o_step.next_lo  = lo_nx;
        o_step.next_hi  = hi_nx;
        o_step.next_mid = f_mid(lo_nx, hi_nx);
    end

endmodule

// File: hw/rtl/sorted_table_binary_search.sv
// Write request: taken while idle, gives no result.
// Search request: one probe of the table per cycle through its single read port,
// at most floor(log2(TABLE_DEPTH))+1 probes (6 at depth 32); the result waits in
// S_DONE until the output register is free and is then registered to the outputs.
// An empty range skips the probes and goes straight to S_DONE.
// Reset (synchronous, active low) clears control only; table contents stay undefined.
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [sts_pkg::CMD_W-1:0]                i_command,
    input  logic [sts_pkg::INDEX_W-1:0]              i_entry_index,
    input  logic signed [sts_pkg::VALUE_W-1:0]       i_entry_value,
    input  logic signed [sts_pkg::VALUE_W-1:0]       i_search_key,
    input  logic [sts_pkg::INDEX_W-1:0]              i_range_start,
    input  logic signed [sts_pkg::RANGE_END_W-1:0]   i_range_end,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic                                     o_found,
    output logic [sts_pkg::INDEX_W-1:0]              o_found_index
);
    import sts_pkg::*;

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int HI_MAX = (TABLE_DEPTH - 1 < PORT_MAX) ? TABLE_DEPTH - 1 : PORT_MAX;
    localparam t_idx HI_MAX_IDX = t_idx'(HI_MAX);

    t_state r_state, n_state;
    t_idx   r_lo, n_lo;
    t_idx   r_hi, n_hi;
    t_idx   r_mid, n_mid;
    t_value r_key, n_key;
    logic   r_res_found, n_res_found;
    logic [INDEX_W-1:0] r_res_index, n_res_index;
    logic   r_out_valid, n_out_valid;
    logic   r_found, n_found;
    logic [INDEX_W-1:0] r_found_index, n_found_index;

    logic          in_fire;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_value        mem_rdata;
    t_idx          start_lo;
    t_idx          hi_raw;
    t_idx          start_hi;
    t_idx          start_mid;
    t_step         step;

    sts_table_ram #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (i_entry_value),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    sts_probe_step u_step (
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_mid   (r_mid),
        .i_entry (mem_rdata),
        .i_key   (r_key),
        .o_step  (step)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign mem_waddr  = AW'(i_entry_index);

    // Clamp the top of the range to the table.
    assign start_lo  = t_idx'({1'b0, i_range_start});
    assign hi_raw    = t_idx'(i_range_end);
    assign start_hi  = (hi_raw > HI_MAX_IDX) ? HI_MAX_IDX : hi_raw;
    assign start_mid = f_mid(start_lo, start_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_key         <= n_key;
        r_res_found   <= n_res_found;
        r_res_index   <= n_res_index;
        r_found       <= n_found;
        r_found_index <= n_found_index;
    end

    always_comb begin
        n_state       = r_state;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_key         = r_key;
        n_res_found   = r_res_found;
        n_res_index   = r_res_index;
        n_out_valid   = r_out_valid;
        n_found       = r_found;
        n_found_index = r_found_index;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = AW'($unsigned(start_mid));

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_command == CMD_WRITE) begin
                        // Drop writes beyond the table.
                        mem_we = (32'(i_entry_index) < 32'(TABLE_DEPTH));
                    end else begin
                        n_key = i_search_key;
                        if (start_lo > start_hi) begin
                            n_res_found = 1'b0;
                            n_res_index = '0;
                            n_state     = S_DONE;
                        end else begin
                            mem_re  = 1'b1;
                            n_lo    = start_lo;
                            n_hi    = start_hi;
                            n_mid   = start_mid;
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE: begin
                if (step.hit) begin
                    n_res_found = 1'b1;
                    n_res_index = INDEX_W'($unsigned(r_mid));
                    n_state     = S_DONE;
                end else if (step.finished) begin
                    n_res_found = 1'b0;
                    n_res_index = '0;
                    n_state     = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'($unsigned(step.next_mid));
                    n_lo      = step.next_lo;
                    n_hi      = step.next_hi;
                    n_mid     = step.next_mid;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_found       = r_res_found;
                    n_found_index = r_res_index;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;

`ifndef SYNTHESIS
    a_probe_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_lo <= r_hi && r_mid >= r_lo && r_mid <= r_hi))
        else $error("probe outside the search window");

    a_search_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_command == CMD_SEARCH) |=> (r_state != S_IDLE))
        else $error("search request did not start a search");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_found_index == '0))
        else $error("not-found result carries a nonzero index");

    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE && !mem_re))
        else $error("table write overlaps a search");
`endif

endmodule
